[design/ges_pkg.sv]
// Package for the graph edge switch engine: sizes, codes, payload structs
// and the command/status structs between controller and datapath.
// No dependencies.
package ges_pkg;

  localparam int NODES   = 64;
  localparam int EDGES   = 256;
  localparam int NODE_W  = 6;
  localparam int SLOT_W  = 8;
  localparam int NIDX_W  = $clog2(NODES);
  localparam int EADDR_W = $clog2(EDGES);
  localparam int CNT_W   = 9;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [CNT_W-1:0] EDGE_LIMIT = CNT_W'(EDGES);

  // register index, byte address is 4*index
  localparam logic [CFG_AW-3:0] REG_EDGE_COUNT = '0;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SWAP = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE   = 3'd0,
    ST_SAME   = 3'd1,
    ST_EXISTS = 3'd2,
    ST_RANGE  = 3'd3,
    ST_LOADED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EDGE_RD,
    S_ADJ_CHK,
    S_WRITE_B,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [SLOT_W-1:0] first_slot;
    logic [SLOT_W-1:0] second_slot;
    logic [NODE_W-1:0] load_head;
    logic [NODE_W-1:0] load_tail;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [NODE_W-1:0] edge_head;
    logic [NODE_W-1:0] edge_tail;
  } out_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] head;
    logic [NODE_W-1:0] tail;
  } edge_t;

  typedef struct packed {
    logic capture;    // take input transaction, read both edge slots
    logic adj_rd;     // read adjacency rows, latch early result
    logic wr_a;       // check targets, first row and slot write
    logic wr_b;       // second row and slot write of a swap
    logic emit;       // move result into output register
    logic clr_wr;     // clearing pass write
  } cmd_t;

  typedef struct packed {
    logic early_done; // result known after edge read
    logic more_b;     // swap allowed, second write needed
    logic out_free;
    logic clr_last;
  } sts_t;

endpackage

[design/ges_ctrl.sv]
// Controller state machine of the graph edge switch engine.
// Depends on ges_pkg (state, command and status types).
module ges_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ges_pkg::sts_t sts,
  output ges_pkg::cmd_t cmd
);

  ges_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ges_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ges_pkg::S_CLEAR: begin
        if (sts.clr_last) state_nxt = ges_pkg::S_IDLE;
      end
      ges_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ges_pkg::S_EDGE_RD;
      end
      ges_pkg::S_EDGE_RD: begin
        state_nxt = sts.early_done ? ges_pkg::S_RESULT : ges_pkg::S_ADJ_CHK;
      end
      ges_pkg::S_ADJ_CHK: begin
        state_nxt = sts.more_b ? ges_pkg::S_WRITE_B : ges_pkg::S_RESULT;
      end
      ges_pkg::S_WRITE_B: begin
        state_nxt = sts.out_free ? ges_pkg::S_IDLE : ges_pkg::S_RESULT;
      end
      ges_pkg::S_RESULT: begin
        if (sts.out_free) state_nxt = ges_pkg::S_IDLE;
      end
      default: state_nxt = ges_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ges_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      ges_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ges_pkg::S_EDGE_RD: begin
        cmd.adj_rd = 1'b1;
      end
      ges_pkg::S_ADJ_CHK: begin
        cmd.wr_a = 1'b1;
      end
      ges_pkg::S_WRITE_B: begin
        cmd.wr_b = 1'b1;
        cmd.emit = sts.out_free;
      end
      ges_pkg::S_RESULT: begin
        cmd.emit = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[design/ges_datapath.sv]
// Datapath of the graph edge switch engine: edge slot memory, adjacency
// row memory, swap checks and the output register. Depends on ges_pkg.
module ges_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ges_pkg::cmd_t                  cmd,
  output ges_pkg::sts_t                  sts,
  input  ges_pkg::in_item_t              in_item,
  input  logic [ges_pkg::CNT_W-1:0]      edge_count,
  input  logic                           out_ready,
  output logic                           out_valid,
  output ges_pkg::out_item_t             out_item
);

  localparam int NODES   = ges_pkg::NODES;
  localparam int NIDX_W  = ges_pkg::NIDX_W;
  localparam int EADDR_W = ges_pkg::EADDR_W;
  localparam int CNT_W   = ges_pkg::CNT_W;
  localparam int NODE_W  = ges_pkg::NODE_W;

  ges_pkg::edge_t     edge_mem [ges_pkg::EDGES];
  logic [NODES-1:0]   adj_mem  [NODES];

  ges_pkg::in_item_t  item_r;
  ges_pkg::edge_t     rd1_r, rd2_r;
  logic [NODES-1:0]   rowa_r, rowb_r;
  ges_pkg::out_item_t res_r, res_nxt;
  ges_pkg::out_item_t out_item_r;
  logic               out_valid_r;
  logic [NIDX_W-1:0]  clr_cnt_r;

  ges_pkg::op_t       op;
  logic               is_load, is_swap;
  logic [CNT_W-1:0]   p1_ext, p2_ext;
  logic               p1_oob, p2_oob, same, cnt_oob;
  logic [NODE_W-1:0]  x1, x2, y1, y2;
  logic               exists, swap_ok, same_row;
  logic [NODES-1:0]   bit_x2, bit_y2, new_a, new_b;
  ges_pkg::status_t   early_st;

  logic                   edge_we;
  logic [EADDR_W-1:0]     edge_wa;
  ges_pkg::edge_t         edge_wd;
  logic                   adj_we;
  logic [NIDX_W-1:0]      adj_wa;
  logic [NODES-1:0]       adj_wd;
  logic [NIDX_W-1:0]      adj_ra_a;

  assign op      = ges_pkg::op_t'(item_r.operation);
  assign is_load = (op == ges_pkg::OP_LOAD);
  assign is_swap = (op == ges_pkg::OP_SWAP);

  assign p1_ext  = CNT_W'(item_r.first_slot);
  assign p2_ext  = CNT_W'(item_r.second_slot);
  assign p1_oob  = (p1_ext >= ges_pkg::EDGE_LIMIT);
  assign p2_oob  = (p2_ext >= ges_pkg::EDGE_LIMIT);
  assign same    = (item_r.first_slot == item_r.second_slot);
  assign cnt_oob = (p1_ext >= edge_count) || (p2_ext >= edge_count) || p1_oob || p2_oob;

  assign x1 = rd1_r.head;
  assign x2 = rd1_r.tail;
  assign y1 = rd2_r.head;
  assign y2 = rd2_r.tail;

  // target bits x1->y2 and y1->x2
  assign exists   = rowa_r[y2[NIDX_W-1:0]] | rowb_r[x2[NIDX_W-1:0]];
  assign swap_ok  = is_swap && !exists;
  assign same_row = (x1[NIDX_W-1:0] == y1[NIDX_W-1:0]);

  assign bit_x2 = NODES'(1) << x2[NIDX_W-1:0];
  assign bit_y2 = NODES'(1) << y2[NIDX_W-1:0];

  // both old bits are cleared before both new bits are set, also when the
  // two heads share one row
  assign new_a = (rowa_r & ~(bit_x2 | (same_row ? bit_y2 : '0)))
               | bit_y2 | (same_row ? bit_x2 : '0);
  assign new_b = (rowb_r & ~(bit_y2 | (same_row ? bit_x2 : '0)))
               | bit_x2 | (same_row ? bit_y2 : '0);

  always_comb begin
    early_st = ges_pkg::ST_DONE;
    priority if (is_swap) begin
      if (same)         early_st = ges_pkg::ST_SAME;
      else if (cnt_oob) early_st = ges_pkg::ST_RANGE;
    end else if (p1_oob) begin
      early_st = ges_pkg::ST_RANGE;
    end else begin
      early_st = ges_pkg::ST_DONE;
    end
  end

  assign sts.early_done = !(is_load && !p1_oob) && !(is_swap && !same && !cnt_oob);
  assign sts.more_b     = swap_ok;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.clr_last   = (clr_cnt_r == NIDX_W'(NODES - 1));

  always_comb begin
    res_nxt = res_r;
    if (cmd.adj_rd) begin
      res_nxt.status    = early_st;
      res_nxt.edge_head = p1_oob ? '0 : x1;
      res_nxt.edge_tail = p1_oob ? '0 : x2;
    end else if (cmd.wr_a) begin
      priority if (is_load) begin
        res_nxt.status    = ges_pkg::ST_LOADED;
        res_nxt.edge_head = item_r.load_head;
        res_nxt.edge_tail = item_r.load_tail;
      end else if (exists) begin
        res_nxt.status    = ges_pkg::ST_EXISTS;
        res_nxt.edge_head = x1;
        res_nxt.edge_tail = x2;
      end else begin
        res_nxt.status    = ges_pkg::ST_DONE;
        res_nxt.edge_head = x1;
        res_nxt.edge_tail = y2;
      end
    end
  end

  // single write port per memory
  always_comb begin
    edge_we = cmd.wr_b || (cmd.wr_a && (is_load || swap_ok));
    edge_wa = cmd.wr_b ? item_r.second_slot[EADDR_W-1:0] : item_r.first_slot[EADDR_W-1:0];
    priority if (cmd.wr_b) begin
      edge_wd = '{head: y1, tail: x2};
    end else if (is_load) begin
      edge_wd = '{head: item_r.load_head, tail: item_r.load_tail};
    end else begin
      edge_wd = '{head: x1, tail: y2};
    end

    adj_we = cmd.clr_wr || cmd.wr_b || (cmd.wr_a && (is_load || swap_ok));
    priority if (cmd.clr_wr) begin
      adj_wa = clr_cnt_r;
      adj_wd = '0;
    end else if (cmd.wr_b) begin
      adj_wa = y1[NIDX_W-1:0];
      adj_wd = new_b;
    end else if (is_load) begin
      adj_wa = item_r.load_head[NIDX_W-1:0];
      adj_wd = rowa_r | (NODES'(1) << item_r.load_tail[NIDX_W-1:0]);
    end else begin
      adj_wa = x1[NIDX_W-1:0];
      adj_wd = new_a;
    end
  end

  assign adj_ra_a = is_load ? item_r.load_head[NIDX_W-1:0] : x1[NIDX_W-1:0];

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    if (cmd.capture) begin
      rd1_r <= edge_mem[in_item.first_slot[EADDR_W-1:0]];
      rd2_r <= edge_mem[in_item.second_slot[EADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    if (cmd.adj_rd) begin
      rowa_r <= adj_mem[adj_ra_a];
      rowb_r <= adj_mem[y1[NIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    res_r <= res_nxt;
    if (cmd.emit) out_item_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      if (cmd.emit)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.clr_wr)   clr_cnt_r <= clr_cnt_r + NIDX_W'(1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[design/graph_edge_switch_engine.sv]
// Graph edge switch engine: holds an edge list of up to 256 slots and a 64 x 64
// adjacency bit matrix, loads and reads edges and performs degree-preserving
// tail swaps between two slots, one transaction at a time. After reset the
// adjacency matrix is cleared one 64-bit row per cycle, so the input is not
// ready until all rows are cleared (configuration writes are taken meanwhile).
// After accept, S_EDGE_RD reads the adjacency rows; reads, out-of-range loads
// and swaps rejected for same slot or range then go to S_RESULT, the others
// to S_ADJ_CHK (target check, first row and slot write). With registered reads
// and single write ports, a performed swap writes its second row and slot in
// S_WRITE_B, which moves the result into the output register if that is free;
// else S_RESULT waits until it is. The next transaction is accepted the cycle
// after that move. A result held in the output register does not block the
// next accept.
// Set edge_count at byte address 0 before issuing swaps.
module graph_edge_switch_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ges_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ges_pkg::out_item_t            out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ges_pkg::CFG_AW-1:0]    paddr,
  input  logic [ges_pkg::CFG_DW-1:0]    pwdata,
  output logic [ges_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  ges_pkg::cmd_t               cmd;
  ges_pkg::sts_t               sts;
  logic [ges_pkg::CNT_W-1:0]   edge_count_r;
  logic                        sel_count;

  assign pready    = 1'b1;
  assign sel_count = (paddr[ges_pkg::CFG_AW-1:2] == ges_pkg::REG_EDGE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_count_r <= '0;
    end else if (psel && penable && pwrite && pready && sel_count) begin
      edge_count_r <= pwdata[ges_pkg::CNT_W-1:0];
    end
  end

  assign prdata = sel_count ? ges_pkg::CFG_DW'(edge_count_r) : '0;

  ges_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ges_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_item    (in_item),
    .edge_count (edge_count_r),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule
